// File: hw/rtl/pnms_pkg.sv
// ----------------------------------------------------------------------------
// pnms_pkg
// Types and constants shared by the PGM/PPM stream parser modules.
// ----------------------------------------------------------------------------
package pnms_pkg;

    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_FIVE  = 8'h35;
    localparam logic [7:0] CH_SIX   = 8'h36;

    localparam logic [7:0] PIX_BAD  = 8'hFF;
    localparam int unsigned QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        FMT_P2 = 2'd0,
        FMT_P3 = 2'd1,
        FMT_P5 = 2'd2,
        FMT_P6 = 2'd3
    } t_fmt;

    typedef enum logic [2:0] {
        PH_P,
        PH_TYPE,
        PH_SPACE,
        PH_WID,
        PH_HGT,
        PH_MAX,
        PH_PIX,
        PH_IDLE
    } t_phase;

    typedef enum logic [1:0] {
        EV_HEADER = 2'd0,
        EV_PIXEL  = 2'd1,
        EV_ERROR  = 2'd2
    } t_event;

    typedef enum logic [2:0] {
        ERR_NO_P   = 3'd0,
        ERR_TYPE   = 3'd1,
        ERR_SPACE  = 3'd2,
        ERR_WIDTH  = 3'd3,
        ERR_HEIGHT = 3'd4,
        ERR_MAXVAL = 3'd5
    } t_err;

    typedef struct packed {
        t_event      kind;
        logic [7:0]  pixel;
        t_err        code;
        t_fmt        fmt;
        logic [15:0] width;
        logic [15:0] height;
        logic [15:0] maxval;
        logic        last;
    } t_cmd;

endpackage

// File: hw/rtl/pnms_front.sv
// ----------------------------------------------------------------------------
// pnms_front
// Byte classifier and header/pixel-token parser; pushes one command per result.
// ----------------------------------------------------------------------------
module pnms_front #(
    parameter int TOKEN_DIGITS = 20
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_data,
    input  logic           i_start,
    input  logic           i_space,
    output logic           o_push,
    output pnms_pkg::t_cmd o_cmd
);
    import pnms_pkg::*;

    localparam int DigW = $clog2(TOKEN_DIGITS);

    t_phase          r_phase, n_phase, w_phase;
    t_fmt            r_format, n_format;
    logic [16:0]     r_tok, n_tok;
    logic [DigW-1:0] r_dig, n_dig;
    logic [15:0]     r_width, n_width;
    logic [15:0]     r_height, n_height;
    logic [15:0]     r_max, n_max;
    logic [33:0]     r_pixels, n_pixels;
    logic [31:0]     r_area;
    logic            w_area_load;

    logic            w_acc;
    logic            w_is_term;
    logic            w_is_dig;
    logic            w_dig_full;
    logic            w_type_ok;
    logic [3:0]      w_digit;
    logic [20:0]     w_hdr_acc;
    logic [16:0]     w_hdr_sat;
    logic [7:0]      w_pix_acc;
    logic [33:0]     w_pix_total;
    logic            w_pix_emit;
    logic            w_pix_last;
    t_err            w_tok_err;

    assign o_ready    = i_space;
    assign w_acc      = i_valid && i_space;
    assign w_phase    = i_start ? PH_P : r_phase;

    assign w_is_term  = (i_data == CH_SPACE) || (i_data == CH_LF);
    assign w_is_dig   = (i_data >= CH_ZERO) && (i_data <= CH_NINE);
    assign w_digit    = 4'(i_data - CH_ZERO);
    assign w_dig_full = r_dig >= DigW'(TOKEN_DIGITS - 1);
    assign w_type_ok  = (i_data == CH_TWO) || (i_data == CH_THREE) ||
                        (i_data == CH_FIVE) || (i_data == CH_SIX);

    assign w_hdr_acc  = 21'({r_tok, 3'b000}) + 21'({r_tok, 1'b0}) + 21'(w_digit);
    assign w_hdr_sat  = (w_hdr_acc > 21'd65536) ? 17'h10000 : w_hdr_acc[16:0];
    assign w_pix_acc  = {r_tok[4:0], 3'b000} + {r_tok[6:0], 1'b0} + {4'b0000, w_digit};

    assign w_pix_total = r_format[0] ? (34'(r_area) + 34'({r_area, 1'b0})) : 34'(r_area);
    assign w_pix_emit  = r_format[1] || w_is_term || !w_is_dig || w_dig_full;
    assign w_pix_last  = (r_pixels == 34'd1);

    always_comb begin
        unique case (w_phase)
            PH_WID:  w_tok_err = ERR_WIDTH;
            PH_HGT:  w_tok_err = ERR_HEIGHT;
            default: w_tok_err = ERR_MAXVAL;
        endcase
    end

    // Next phase.
    always_comb begin
        n_phase = w_phase;
        unique case (w_phase)
            PH_P:     n_phase = (i_data == CH_P) ? PH_TYPE : PH_IDLE;
            PH_TYPE:  n_phase = w_type_ok ? PH_SPACE : PH_IDLE;
            PH_SPACE: n_phase = (i_data == CH_SPACE) ? PH_WID : PH_IDLE;
            PH_WID: begin
                if (w_is_term) begin
                    n_phase = r_tok[16] ? PH_IDLE : PH_HGT;
                end else if (!w_is_dig || w_dig_full) begin
                    n_phase = PH_IDLE;
                end
            end
            PH_HGT: begin
                if (w_is_term) begin
                    n_phase = r_tok[16] ? PH_IDLE : PH_MAX;
                end else if (!w_is_dig || w_dig_full) begin
                    n_phase = PH_IDLE;
                end
            end
            PH_MAX: begin
                if (w_is_term) begin
                    n_phase = (r_tok[16] || (r_area == 32'd0)) ? PH_IDLE : PH_PIX;
                end else if (!w_is_dig || w_dig_full) begin
                    n_phase = PH_IDLE;
                end
            end
            PH_PIX:  n_phase = (w_pix_emit && w_pix_last) ? PH_IDLE : PH_PIX;
            PH_IDLE: n_phase = PH_IDLE;
        endcase
    end

    // Datapath updates and command generation.
    always_comb begin
        n_format    = r_format;
        n_tok       = r_tok;
        n_dig       = r_dig;
        n_width     = r_width;
        n_height    = r_height;
        n_max       = r_max;
        n_pixels    = r_pixels;
        w_area_load = 1'b0;
        o_push      = 1'b0;
        o_cmd       = '{kind: EV_PIXEL, pixel: 8'd0, code: ERR_NO_P, fmt: r_format,
                        width: r_width, height: r_height, maxval: r_max, last: 1'b0};
        unique case (w_phase)
            PH_P: begin
                if (i_data != CH_P) begin
                    o_push     = 1'b1;
                    o_cmd.kind = EV_ERROR;
                    o_cmd.code = ERR_NO_P;
                end
            end
            PH_TYPE: begin
                unique case (i_data)
                    CH_TWO:   n_format = FMT_P2;
                    CH_THREE: n_format = FMT_P3;
                    CH_FIVE:  n_format = FMT_P5;
                    CH_SIX:   n_format = FMT_P6;
                    default: begin
                        o_push     = 1'b1;
                        o_cmd.kind = EV_ERROR;
                        o_cmd.code = ERR_TYPE;
                    end
                endcase
            end
            PH_SPACE: begin
                if (i_data != CH_SPACE) begin
                    o_push     = 1'b1;
                    o_cmd.kind = EV_ERROR;
                    o_cmd.code = ERR_SPACE;
                end else begin
                    n_tok = '0;
                    n_dig = '0;
                end
            end
            PH_WID, PH_HGT, PH_MAX: begin
                if (w_is_term) begin
                    n_tok = '0;
                    n_dig = '0;
                    if (r_tok[16]) begin
                        o_push     = 1'b1;
                        o_cmd.kind = EV_ERROR;
                        o_cmd.code = w_tok_err;
                    end else if (w_phase == PH_WID) begin
                        n_width = r_tok[15:0];
                    end else if (w_phase == PH_HGT) begin
                        n_height    = r_tok[15:0];
                        w_area_load = 1'b1;
                    end else begin
                        n_max        = r_tok[15:0];
                        n_pixels     = w_pix_total;
                        o_push       = 1'b1;
                        o_cmd.kind   = EV_HEADER;
                        o_cmd.maxval = r_tok[15:0];
                    end
                end else if (!w_is_dig || w_dig_full) begin
                    o_push     = 1'b1;
                    o_cmd.kind = EV_ERROR;
                    o_cmd.code = w_tok_err;
                end else begin
                    n_tok = w_hdr_sat;
                    n_dig = r_dig + DigW'(1);
                end
            end
            PH_PIX: begin
                if (w_pix_emit) begin
                    o_push     = 1'b1;
                    o_cmd.kind = EV_PIXEL;
                    o_cmd.last = w_pix_last;
                    n_pixels   = r_pixels - 34'd1;
                    if (r_format[1]) begin
                        o_cmd.pixel = i_data;
                    end else begin
                        o_cmd.pixel = w_is_term ? r_tok[7:0] : PIX_BAD;
                        n_tok       = '0;
                        n_dig       = '0;
                    end
                end else begin
                    n_tok = {9'd0, w_pix_acc};
                    n_dig = r_dig + DigW'(1);
                end
            end
            PH_IDLE: begin
            end
        endcase
        o_push = o_push && w_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_P;
            r_format <= FMT_P2;
            r_tok    <= '0;
            r_dig    <= '0;
            r_pixels <= '0;
        end else if (w_acc) begin
            r_phase  <= n_phase;
            r_format <= n_format;
            r_tok    <= n_tok;
            r_dig    <= n_dig;
            r_pixels <= n_pixels;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_width  <= n_width;
            r_height <= n_height;
            r_max    <= n_max;
        end
        if (w_acc && w_area_load) begin
            r_area <= 32'(r_width) * 32'(r_tok[15:0]);
        end
    end

endmodule

// File: hw/rtl/pnms_queue.sv
// ----------------------------------------------------------------------------
// pnms_queue
// Small command queue between the parser front and the output back end.
// ----------------------------------------------------------------------------
module pnms_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pnms_pkg::t_cmd i_cmd,
    output logic           o_space,
    output logic           o_valid,
    output pnms_pkg::t_cmd o_cmd,
    input  logic           i_pop
);
    import pnms_pkg::*;

    localparam int PtrW = $clog2(QUEUE_DEPTH);
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    t_cmd            r_mem [QUEUE_DEPTH];
    logic [PtrW-1:0] r_wr;
    logic [PtrW-1:0] r_rd;
    logic [CntW-1:0] r_count;
    logic            w_pop;

    assign o_space = r_count != CntW'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rd];
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PtrW'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + PtrW'(1);
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + CntW'(1);
            end else if (!i_push && w_pop) begin
                r_count <= r_count - CntW'(1);
            end
        end
    end

endmodule

// File: hw/rtl/pnms_back.sv
// ----------------------------------------------------------------------------
// pnms_back
// Output stage: formats queued commands into result transfers.
// ----------------------------------------------------------------------------
module pnms_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  pnms_pkg::t_cmd i_cmd,
    output logic           o_q_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output pnms_pkg::t_cmd o_res
);
    import pnms_pkg::*;

    logic r_valid;
    t_cmd r_res;
    t_cmd n_res;

    assign o_q_pop = i_q_valid && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    // Fields that do not belong to an event are forced to zero.
    always_comb begin
        n_res = i_cmd;
        unique case (i_cmd.kind)
            EV_HEADER: begin
                n_res.pixel = 8'd0;
                n_res.code  = ERR_NO_P;
                n_res.last  = 1'b0;
            end
            EV_PIXEL: begin
                n_res.code = ERR_NO_P;
            end
            default: begin
                n_res.pixel  = 8'd0;
                n_res.fmt    = FMT_P2;
                n_res.width  = 16'd0;
                n_res.height = 16'd0;
                n_res.maxval = 16'd0;
                n_res.last   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_ready) begin
            r_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_res <= n_res;
        end
    end

endmodule

// File: hw/rtl/pnm_stream_parser.sv
// ----------------------------------------------------------------------------
// pnm_stream_parser
// Byte-serial PGM/PPM (P2, P3, P5, P6) parser with streaming ports.
// ----------------------------------------------------------------------------
// The parser accepts one file byte per clock cycle while the command queue
// has space, and gives at most one result per byte, in byte order. A result
// passes through the four-entry command queue and then the output register
// before it appears on the master side. The front state machine parses each
// byte as it is accepted, which sets the rate; while the output is stalled,
// the output register and the queue absorb up to five results, and once the
// queue is full the input is held off for every byte.
module pnm_stream_parser #(
    parameter int TOKEN_DIGITS = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] start_of_file
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] pixel_value, [10:8] error_code, [12:11] image_format,
    // [28:13] image_width, [44:29] image_height, [60:45] max_value, [63:61] zero
    output logic [63:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // [1:0] event_res
    output logic        m_axis_tlast    // last_pixel
);
    import pnms_pkg::*;

    logic w_space;
    logic w_push;
    t_cmd w_push_cmd;
    logic w_q_valid;
    t_cmd w_q_cmd;
    logic w_pop;
    t_cmd w_res;

    pnms_front #(
        .TOKEN_DIGITS(TOKEN_DIGITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .i_start (s_axis_tuser),
        .i_space (w_space),
        .o_push  (w_push),
        .o_cmd   (w_push_cmd)
    );

    pnms_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_space (w_space),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .i_pop   (w_pop)
    );

    pnms_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_cmd     (w_q_cmd),
        .o_q_pop   (w_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_res     (w_res)
    );

    assign m_axis_tdata = {3'b000, w_res.maxval, w_res.height, w_res.width,
                           w_res.fmt, w_res.code, w_res.pixel};
    assign m_axis_tuser = w_res.kind;
    assign m_axis_tlast = w_res.last;

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking regression for the PGM/PPM stream parser. A short table of
// hand-written bytes covers every error code, an empty header token and the
// extreme sample value. It is followed by random files, most of them
// well-formed with random content and the rest broken or noisy. Each accepted
// byte is run through a behavioral parser that predicts the results, and every
// result transfer is compared field by field with the oldest expected result.
// Both sides idle at random, and the receiver holds off once for a long
// stretch so that the parser fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb;
    import pnms_pkg::*;

    localparam int TOKEN_DIGITS = 20;
    localparam int RANDOM_ITEMS = 700;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int CYCLE_LIMIT  = 200000;

    typedef enum logic [1:0] {
        CHK_PREDICT,
        CHK_NONE,
        CHK_RESULT
    } t_check;

    typedef enum {
        FLT_NONE,
        FLT_NO_P,
        FLT_TYPE,
        FLT_SPACE,
        FLT_BIG,
        FLT_BAD_CHAR,
        FLT_LONG,
        FLT_CUT
    } t_fault;

    typedef struct packed {
        logic [7:0] b;
        logic       sof;
        t_check     mode;
        t_cmd       res;
    } t_stim;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic        s_axis_tuser = 1'b0;    // [0] start_of_file
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [7:0] pixel_value, [10:8] error_code, [12:11] image_format,
    // [28:13] image_width, [44:29] image_height, [60:45] max_value
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;           // [1:0] event_res
    logic        m_axis_tlast;

    t_stim stim[$];
    t_stim directed_rows [34];
    t_cmd  result_q[$];
    int    n_accepted = 0;
    int    results_seen = 0;
    int    fails = 0;
    int    cycle_count = 0;
    logic  hold_off = 1'b0;

    t_phase      pr_phase = PH_P;
    t_fmt        pr_fmt = FMT_P2;
    int unsigned tok_val = 0;
    int unsigned tok_len = 0;
    logic [15:0] hdr_w = 16'd0;
    logic [15:0] hdr_h = 16'd0;
    logic [15:0] hdr_max = 16'd0;
    logic [33:0] samples_left = 34'd0;

    pnm_stream_parser #(
        .TOKEN_DIGITS(TOKEN_DIGITS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_cmd make_cmd(t_event k, logic [7:0] px, t_err c, t_fmt f,
                                      logic [15:0] w, logic [15:0] h, logic [15:0] m,
                                      logic l);
        t_cmd r;
        r.kind   = k;
        r.pixel  = px;
        r.code   = c;
        r.fmt    = f;
        r.width  = w;
        r.height = h;
        r.maxval = m;
        r.last   = l;
        return r;
    endfunction

    function automatic t_cmd err_cmd(t_err c);
        return make_cmd(EV_ERROR, 8'h00, c, FMT_P2, 16'd0, 16'd0, 16'd0, 1'b0);
    endfunction

    function automatic t_cmd parse_fail(t_err c);
        pr_phase = PH_IDLE;
        return err_cmd(c);
    endfunction

    function automatic t_cmd sample_out(logic [7:0] v);
        samples_left = samples_left - 34'd1;
        if (samples_left == 34'd0)
            pr_phase = PH_IDLE;
        return make_cmd(EV_PIXEL, v, ERR_NO_P, pr_fmt, hdr_w, hdr_h, hdr_max,
                        samples_left == 34'd0);
    endfunction

    // Advances the parser state by one byte; returns 1 when the byte gives a result.
    function automatic bit parse_byte(input logic [7:0] b, input logic sof,
                                      output t_cmd res);
        bit          is_term;
        bit          is_dig;
        int unsigned v;
        t_err        code;
        is_term = (b == CH_SPACE) || (b == CH_LF);
        is_dig  = (b >= CH_ZERO) && (b <= CH_NINE);
        res = '0;
        if (sof) begin
            pr_phase     = PH_P;
            pr_fmt       = FMT_P2;
            tok_val      = 0;
            tok_len      = 0;
            hdr_w        = 16'd0;
            hdr_h        = 16'd0;
            hdr_max      = 16'd0;
            samples_left = 34'd0;
        end
        case (pr_phase)
            PH_P: begin
                if (b != CH_P) begin
                    res = parse_fail(ERR_NO_P);
                    return 1'b1;
                end
                pr_phase = PH_TYPE;
            end
            PH_TYPE: begin
                if (b == CH_TWO) pr_fmt = FMT_P2;
                else if (b == CH_THREE) pr_fmt = FMT_P3;
                else if (b == CH_FIVE) pr_fmt = FMT_P5;
                else if (b == CH_SIX) pr_fmt = FMT_P6;
                else begin
                    res = parse_fail(ERR_TYPE);
                    return 1'b1;
                end
                pr_phase = PH_SPACE;
            end
            PH_SPACE: begin
                if (b != CH_SPACE) begin
                    res = parse_fail(ERR_SPACE);
                    return 1'b1;
                end
                pr_phase = PH_WID;
                tok_val  = 0;
                tok_len  = 0;
            end
            PH_WID, PH_HGT, PH_MAX: begin
                code = (pr_phase == PH_WID) ? ERR_WIDTH :
                       (pr_phase == PH_HGT) ? ERR_HEIGHT : ERR_MAXVAL;
                if (is_term) begin
                    v       = tok_val;
                    tok_val = 0;
                    tok_len = 0;
                    if (v > 65535) begin
                        res = parse_fail(code);
                        return 1'b1;
                    end
                    if (pr_phase == PH_WID) begin
                        hdr_w    = v[15:0];
                        pr_phase = PH_HGT;
                        return 1'b0;
                    end
                    if (pr_phase == PH_HGT) begin
                        hdr_h    = v[15:0];
                        pr_phase = PH_MAX;
                        return 1'b0;
                    end
                    hdr_max      = v[15:0];
                    samples_left = 34'(hdr_w) * 34'(hdr_h);
                    if (pr_fmt == FMT_P3 || pr_fmt == FMT_P6)
                        samples_left = samples_left * 34'd3;
                    pr_phase = (samples_left == 34'd0) ? PH_IDLE : PH_PIX;
                    res = make_cmd(EV_HEADER, 8'h00, ERR_NO_P, pr_fmt, hdr_w, hdr_h,
                                   hdr_max, 1'b0);
                    return 1'b1;
                end
                if (!is_dig || tok_len + 1 >= TOKEN_DIGITS) begin
                    res = parse_fail(code);
                    return 1'b1;
                end
                tok_val = tok_val * 10 + (b - CH_ZERO);
                if (tok_val > 65536)
                    tok_val = 65536;
                tok_len++;
            end
            PH_PIX: begin
                if (pr_fmt == FMT_P5 || pr_fmt == FMT_P6) begin
                    res = sample_out(b);
                    return 1'b1;
                end
                if (is_term) begin
                    v       = tok_val;
                    tok_val = 0;
                    tok_len = 0;
                    res = sample_out(v[7:0]);
                    return 1'b1;
                end
                if (!is_dig || tok_len + 1 >= TOKEN_DIGITS) begin
                    tok_val = 0;
                    tok_len = 0;
                    res = sample_out(PIX_BAD);
                    return 1'b1;
                end
                tok_val = (tok_val * 10 + (b - CH_ZERO)) & 32'hFF;
                tok_len++;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    task automatic add_row(input logic [7:0] b, input logic sof, input t_check mode,
                           input t_cmd res);
        t_stim s;
        s.b    = b;
        s.sof  = sof;
        s.mode = mode;
        s.res  = res;
        stim.push_back(s);
    endtask

    task automatic add_byte(input logic [7:0] b);
        add_row(b, 1'b0, CHK_PREDICT, '0);
    endtask

    function automatic logic [7:0] rnd_term();
        return ($urandom_range(0, 1) != 0) ? CH_SPACE : CH_LF;
    endfunction

    function automatic logic [7:0] rnd_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rnd_junk();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_SPACE || b == CH_LF);
        return b;
    endfunction

    // Decimal token with optional leading zeros, or no digits at all for zero.
    task automatic add_number(input int unsigned v);
        string s;
        int    i;
        s = $sformatf("%0d", v);
        if (v == 0 && $urandom_range(0, 3) == 0)
            s = "";
        else
            repeat (($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0)
                add_byte(CH_ZERO);
        for (i = 0; i < s.len(); i++)
            add_byte(s[i]);
        add_byte(rnd_term());
    endtask

    task automatic add_file();
        t_fault      fault;
        t_fmt        f;
        logic [7:0]  b;
        int unsigned dims[3];
        int unsigned count;
        int          sel;
        int          bad_field;
        int          k;
        int          roll;
        fault = ($urandom_range(0, 99) < 75) ? FLT_NONE : t_fault'($urandom_range(1, 7));
        f = t_fmt'($urandom_range(0, 3));
        if (fault == FLT_NO_P) begin
            do
                b = 8'($urandom_range(0, 255));
            while (b == CH_P);
            add_row(b, 1'b1, CHK_PREDICT, '0);
        end else begin
            add_row(CH_P, 1'b1, CHK_PREDICT, '0);
        end
        if (fault == FLT_TYPE) begin
            do
                b = 8'($urandom_range(0, 255));
            while (b inside {CH_TWO, CH_THREE, CH_FIVE, CH_SIX});
            add_byte(b);
        end else begin
            case (f)
                FMT_P2:  add_byte(CH_TWO);
                FMT_P3:  add_byte(CH_THREE);
                FMT_P5:  add_byte(CH_FIVE);
                default: add_byte(CH_SIX);
            endcase
        end
        if (fault == FLT_SPACE) begin
            do
                b = 8'($urandom_range(0, 255));
            while (b == CH_SPACE);
            add_byte(b);
        end else begin
            add_byte(CH_SPACE);
        end
        if (fault == FLT_NO_P || fault == FLT_TYPE || fault == FLT_SPACE) begin
            repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(0, 255)));
            return;
        end

        sel = $urandom_range(0, 19);
        if (sel == 0) begin
            dims[0] = 65535;
            dims[1] = 0;
        end else if (sel == 1) begin
            dims[0] = 0;
            dims[1] = 65535;
        end else if (sel == 2 && (f == FMT_P5 || f == FMT_P6)) begin
            dims[0] = $urandom_range(5, 40);
            dims[1] = 1;
        end else begin
            dims[0] = $urandom_range(1, 4);
            dims[1] = $urandom_range(1, 3);
        end
        dims[2] = ($urandom_range(0, 9) == 0) ? 65535 : $urandom_range(0, 255);

        bad_field = $urandom_range(0, 2);
        for (k = 0; k < 3; k++) begin
            if (k == bad_field && fault == FLT_BIG) begin
                add_number(($urandom_range(0, 1) != 0) ? 65536 : $urandom_range(65537, 999999));
            end else if (k == bad_field && fault == FLT_BAD_CHAR) begin
                repeat ($urandom_range(0, 3)) add_byte(rnd_digit());
                add_byte(rnd_junk());
            end else if (k == bad_field && fault == FLT_LONG) begin
                repeat ($urandom_range(TOKEN_DIGITS - 1, TOKEN_DIGITS + 2)) add_byte(CH_ZERO);
                add_byte(rnd_term());
            end else begin
                add_number(dims[k]);
            end
        end
        if (fault != FLT_NONE && fault != FLT_CUT) begin
            repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(0, 255)));
            return;
        end

        count = dims[0] * dims[1] * ((f == FMT_P3 || f == FMT_P6) ? 3 : 1);
        if (fault == FLT_CUT)
            count = $urandom_range(0, count);
        repeat (count) begin
            if (f == FMT_P5 || f == FMT_P6) begin
                add_byte(8'($urandom_range(0, 255)));
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 80) begin
                    add_number(($urandom_range(0, 9) == 0) ? $urandom_range(0, 99999)
                                                            : $urandom_range(0, 300));
                end else if (roll < 88) begin
                    repeat ($urandom_range(0, 2)) add_byte(rnd_digit());
                    add_byte(rnd_junk());
                end else if (roll < 94) begin
                    repeat (TOKEN_DIGITS) add_byte(rnd_digit());
                end else begin
                    add_byte(rnd_term());
                end
            end
        end
        repeat ($urandom_range(0, 2)) add_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned seen);
        if (want != seen) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_cmd seen;
        t_cmd want;
        t_cmd pred;
        bit   made;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            seen = make_cmd(t_event'(m_axis_tuser), m_axis_tdata[7:0],
                            t_err'(m_axis_tdata[10:8]), t_fmt'(m_axis_tdata[12:11]),
                            m_axis_tdata[28:13], m_axis_tdata[44:29],
                            m_axis_tdata[60:45], m_axis_tlast);
            if (result_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got event %0d",
                         $time, m_axis_tuser);
                fails++;
            end else begin
                want = result_q.pop_front();
                check_field("event_res", want.kind, seen.kind);
                check_field("pixel_value", want.pixel, seen.pixel);
                check_field("error_code", want.code, seen.code);
                check_field("image_format", want.fmt, seen.fmt);
                check_field("image_width", want.width, seen.width);
                check_field("image_height", want.height, seen.height);
                check_field("max_value", want.maxval, seen.maxval);
                check_field("last_pixel", want.last, seen.last);
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            made = parse_byte(s_axis_tdata, s_axis_tuser, pred);
            case (stim[n_accepted].mode)
                CHK_RESULT: result_q.push_back(stim[n_accepted].res);
                CHK_NONE:   ;
                default:    if (made) result_q.push_back(pred);
            endcase
            n_accepted++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("pnm_stream_parser regression: fail");
            $finish;
        end
    end

    initial begin
        int gap;
        bit pressure_done;
        pressure_done = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!pressure_done && results_seen >= 60) begin
                pressure_done = 1'b1;
                m_axis_tready <= 1'b0;
                hold_off <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off <= 1'b0;
            end else begin
                gap = (((results_seen / 50) % 4) == 3) ? 0 : $urandom_range(0, 10);
                if (gap != 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    initial begin
        int gap;
        int i;
        directed_rows = '{
            '{CH_P,     1'b0, CHK_NONE,    '0},
            '{CH_FIVE,  1'b0, CHK_PREDICT, '0},
            '{CH_SPACE, 1'b0, CHK_PREDICT, '0},
            '{"1",      1'b0, CHK_PREDICT, '0},
            '{CH_SPACE, 1'b0, CHK_PREDICT, '0},
            '{"1",      1'b0, CHK_PREDICT, '0},
            '{CH_LF,    1'b0, CHK_PREDICT, '0},
            '{CH_LF,    1'b0, CHK_RESULT,
              make_cmd(EV_HEADER, 8'h00, ERR_NO_P, FMT_P5, 16'd1, 16'd1, 16'd0, 1'b0)},
            '{8'hFF,    1'b0, CHK_RESULT,
              make_cmd(EV_PIXEL, 8'hFF, ERR_NO_P, FMT_P5, 16'd1, 16'd1, 16'd0, 1'b1)},
            '{CH_P,     1'b0, CHK_NONE,    '0},
            '{8'h00,    1'b1, CHK_RESULT,  err_cmd(ERR_NO_P)},
            '{8'hFF,    1'b0, CHK_NONE,    '0},
            '{CH_P,     1'b1, CHK_PREDICT, '0},
            '{"7",      1'b0, CHK_RESULT,  err_cmd(ERR_TYPE)},
            '{CH_P,     1'b1, CHK_PREDICT, '0},
            '{CH_TWO,   1'b0, CHK_PREDICT, '0},
            '{CH_LF,    1'b0, CHK_RESULT,  err_cmd(ERR_SPACE)},
            '{CH_P,     1'b1, CHK_PREDICT, '0},
            '{CH_THREE, 1'b0, CHK_PREDICT, '0},
            '{CH_SPACE, 1'b0, CHK_PREDICT, '0},
            '{"/",      1'b0, CHK_RESULT,  err_cmd(ERR_WIDTH)},
            '{CH_P,     1'b1, CHK_PREDICT, '0},
            '{CH_SIX,   1'b0, CHK_PREDICT, '0},
            '{CH_SPACE, 1'b0, CHK_PREDICT, '0},
            '{CH_SPACE, 1'b0, CHK_PREDICT, '0},
            '{":",      1'b0, CHK_RESULT,  err_cmd(ERR_HEIGHT)},
            '{CH_P,     1'b1, CHK_PREDICT, '0},
            '{CH_TWO,   1'b0, CHK_PREDICT, '0},
            '{CH_SPACE, 1'b0, CHK_PREDICT, '0},
            '{"1",      1'b0, CHK_PREDICT, '0},
            '{CH_SPACE, 1'b0, CHK_PREDICT, '0},
            '{"1",      1'b0, CHK_PREDICT, '0},
            '{CH_LF,    1'b0, CHK_PREDICT, '0},
            '{"x",      1'b0, CHK_RESULT,  err_cmd(ERR_MAXVAL)}
        };
        foreach (directed_rows[r])
            stim.push_back(directed_rows[r]);
        while (stim.size() < $size(directed_rows) + RANDOM_ITEMS)
            add_file();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < stim.size(); i++) begin
            gap = (hold_off || ((i / 80) % 4) == 3) ? 0 : $urandom_range(0, 10);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= stim[i].b;
            s_axis_tuser  <= stim[i].sof;
            do @(posedge i_clk); while (!s_axis_tready);
        end
        s_axis_tvalid <= 1'b0;

        for (i = 0; i < DRAIN_LIMIT && result_q.size() != 0; i++)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (result_q.size() != 0) begin
            $display("%0t: %0d results missing, expected event %0d, got none",
                     $time, result_q.size(), result_q[0].kind);
            fails++;
        end
        if (fails == 0)
            $display("pnm_stream_parser regression: pass");
        else
            $display("pnm_stream_parser regression: fail");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/pnms_pkg.sv
hw/rtl/pnms_front.sv
hw/rtl/pnms_queue.sv
hw/rtl/pnms_back.sv
hw/rtl/pnm_stream_parser.sv
bench/tb.sv
